[rtl/core/ors_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the 1-Wire ROM search stepper.
// No dependencies; every other file in rtl/core refers to this package.
package ors_pkg;

   // Default ROM code length in bits, and the width of a bit position (1..64, plus 64 preset).
   localparam int ID_BITS_DEF = 64;
   localparam int POS_W       = 7;
   localparam int FDISC_W     = 4;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int BYTE_W      = 8;

   // Discrepancy preset by a family-prefix restart, and the first position past the family byte.
   localparam logic [POS_W-1:0] PREFIX_DISC  = POS_W'(64);
   localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);

   typedef enum logic [CMD_W-1:0] {
      CMD_RESTART = 2'd0,
      CMD_PREFIX  = 2'd1,
      CMD_BEGIN   = 2'd2,
      CMD_BITS    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACK        = 3'd0,
      ST_SEND       = 3'd1,
      ST_WRITE      = 3'd2,
      ST_FOUND      = 3'd3,
      ST_NONE       = 3'd4,
      ST_WRITE_NONE = 3'd5,
      ST_REJECT     = 3'd6
   } status_type;

   // Request payload as held in the input register.
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] fam_byte;
      logic              presence;
      logic [BYTE_W-1:0] search_opcode;
      logic              id_bit;
      logic              complement_bit;
   } req_item_type;

   // Search bookkeeping carried from one step to the next (ROM image kept apart).
   typedef struct packed {
      logic [POS_W-1:0]   last_disc;
      logic               last_dev;
      logic [FDISC_W-1:0] fam_disc;
      logic [POS_W-1:0]   bit_pos;
      logic [POS_W-1:0]   zero_mark;
      logic               pass_active;
   } ctl_state_type;

   // Narrow result fields of one step (device address travels apart).
   typedef struct packed {
      status_type         status;
      logic               write_bit;
      logic [BYTE_W-1:0]  send_byte;
      logic               last_device;
      logic [FDISC_W-1:0] family_discrepancy;
   } rsp_item_type;

endpackage

[rtl/core/ors_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the ROM search stepper: valid/ready plus one command item.
// Depends on ors_pkg for field widths.
interface ors_req_if;
   logic                        valid;
   logic                        ready;
   logic [ors_pkg::CMD_W-1:0]   command;
   logic [ors_pkg::BYTE_W-1:0]  fam_byte;
   logic                        presence;
   logic [ors_pkg::BYTE_W-1:0]  search_opcode;
   logic                        id_bit;
   logic                        complement_bit;

   modport source (
      output valid, command, fam_byte, presence, search_opcode, id_bit, complement_bit,
      input  ready
   );
   modport sink (
      input  valid, command, fam_byte, presence, search_opcode, id_bit, complement_bit,
      output ready
   );
endinterface

[rtl/core/ors_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel of the ROM search stepper: valid/ready plus one result item.
// Depends on ors_pkg for field widths and the default ROM code length.
interface ors_rsp_if #(
   parameter int ID_BITS = ors_pkg::ID_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [ors_pkg::STATUS_W-1:0] status;
   logic                         write_bit;
   logic [ors_pkg::BYTE_W-1:0]   send_byte;
   logic [ID_BITS-1:0]           device_address;
   logic                         last_device;
   logic [ors_pkg::FDISC_W-1:0]  family_discrepancy;

   modport source (
      output valid, status, write_bit, send_byte, device_address, last_device,
             family_discrepancy,
      input  ready
   );
   modport sink (
      input  valid, status, write_bit, send_byte, device_address, last_device,
             family_discrepancy,
      output ready
   );
endinterface

[rtl/core/ors_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one search step, purely combinational.
// Depends on ors_pkg for the command, status and state types.
module ors_step #(
   parameter int ID_BITS = ors_pkg::ID_BITS_DEF
) (
   input  ors_pkg::req_item_type  item,
   input  ors_pkg::ctl_state_type ctl_q,
   input  logic [ID_BITS-1:0]     rom_q,
   output ors_pkg::ctl_state_type ctl_d,
   output logic [ID_BITS-1:0]     rom_d,
   output ors_pkg::rsp_item_type  result,
   output logic [ID_BITS-1:0]     dev_addr
);
   localparam int IDX_W = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

   function automatic ors_pkg::ctl_state_type clear_search(ors_pkg::ctl_state_type s);
      ors_pkg::ctl_state_type r;
      r             = s;
      r.last_disc   = '0;
      r.last_dev    = 1'b0;
      r.fam_disc    = '0;
      r.pass_active = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [ors_pkg::POS_W-1:0] pos;
      logic [IDX_W-1:0]          idx;
      logic                      dir;

      pos      = ctl_q.bit_pos;
      idx      = IDX_W'(pos - ors_pkg::POS_W'(1));
      dir      = 1'b0;
      ctl_d    = ctl_q;
      rom_d    = rom_q;
      dev_addr = '0;
      result.status    = ors_pkg::ST_ACK;
      result.write_bit = 1'b0;
      result.send_byte = '0;

      unique case (ors_pkg::cmd_type'(item.command))
         ors_pkg::CMD_RESTART: begin
            rom_d = '0;
            ctl_d = clear_search(ctl_q);
         end
         ors_pkg::CMD_PREFIX: begin
            rom_d           = ID_BITS'(item.fam_byte);
            ctl_d           = clear_search(ctl_q);
            ctl_d.last_disc = ors_pkg::PREFIX_DISC;
         end
         ors_pkg::CMD_BEGIN: begin
            if (ctl_q.last_dev || !item.presence) begin
               ctl_d         = clear_search(ctl_q);
               result.status = ors_pkg::ST_NONE;
            end else begin
               ctl_d.pass_active = 1'b1;
               ctl_d.bit_pos     = ors_pkg::POS_W'(1);
               ctl_d.zero_mark   = '0;
               result.status     = ors_pkg::ST_SEND;
               result.send_byte  = item.search_opcode;
            end
         end
         ors_pkg::CMD_BITS: begin
            priority if (!ctl_q.pass_active) begin
               result.status = ors_pkg::ST_REJECT;
            end else if (item.id_bit && item.complement_bit) begin
               ctl_d         = clear_search(ctl_q);
               result.status = ors_pkg::ST_NONE;
            end else begin
               if (item.id_bit != item.complement_bit) begin
                  dir = item.id_bit;
               end else begin
                  // Both devices answer: follow the previous path below the last fork, take one at it, zero above.
                  if (pos < ctl_q.last_disc) begin
                     dir = rom_q[idx];
                  end else begin
                     dir = (pos == ctl_q.last_disc);
                  end
                  if (!dir) begin
                     ctl_d.zero_mark = pos;
                     if (pos < ors_pkg::FAMILY_LIMIT) begin
                        ctl_d.fam_disc = ors_pkg::FDISC_W'(pos);
                     end
                  end
               end
               rom_d[idx]       = dir;
               result.write_bit = dir;
               result.status    = ors_pkg::ST_WRITE;

               if (pos >= ors_pkg::POS_W'(ID_BITS)) begin
                  ctl_d.pass_active = 1'b0;
                  ctl_d.bit_pos     = ors_pkg::POS_W'(1);
                  ctl_d.last_disc   = ctl_d.zero_mark;
                  if (ctl_d.zero_mark == '0) begin
                     ctl_d.last_dev = 1'b1;
                  end
                  if (rom_d[7:0] == 8'd0) begin
                     ctl_d         = clear_search(ctl_d);
                     result.status = ors_pkg::ST_WRITE_NONE;
                  end else begin
                     result.status = ors_pkg::ST_FOUND;
                     dev_addr      = rom_d;
                  end
               end else begin
                  ctl_d.bit_pos = pos + ors_pkg::POS_W'(1);
               end
            end
         end
      endcase

      result.last_device        = ctl_d.last_dev;
      result.family_discrepancy = ctl_d.fam_disc;
   end
endmodule

[rtl/core/onewire_rom_search_stepper.sv]
`timescale 1ns / 1ps
// Top level of the 1-Wire ROM search stepper: input register, step logic, result register.
// Depends on ors_pkg, ors_req_if, ors_rsp_if and ors_step.
//
//   channel   | dir | payload
//   ----------+-----+---------------------------------------------------------------
//   req_chan  | in  | command, fam_byte, presence, search_opcode, id_bit,
//             |     | complement_bit
//   rsp_chan  | out | status, write_bit, send_byte, device_address, last_device,
//             |     | family_discrepancy
//
// One request transfer per cycle is taken unless the response stalls; each produces
// exactly one response transfer. The item first sits in the input register, then the
// step logic updates the search state and loads the result register, which drives valid.
// Reset (synchronous, active high) empties both registers, clears the search state and
// sets the bit position to one. A stalled response holds the result register and the
// input register; the request side keeps taking transfers while either register has room.
module onewire_rom_search_stepper #(
   parameter int ID_BITS = ors_pkg::ID_BITS_DEF
) (
   input logic           clock,
   input logic           reset,
   ors_req_if.sink       req_chan,
   ors_rsp_if.source     rsp_chan
);
   // Input register
   logic                  in_valid_ff;
   ors_pkg::req_item_type in_item_ff;

   // Search state
   ors_pkg::ctl_state_type ctl_ff;
   ors_pkg::ctl_state_type ctl_in;
   logic [ID_BITS-1:0]     rom_ff;
   logic [ID_BITS-1:0]     rom_in;

   // Result register
   logic                  rsp_valid_ff;
   ors_pkg::rsp_item_type rsp_item_ff;
   ors_pkg::rsp_item_type rsp_item_in;
   logic [ID_BITS-1:0]    rsp_addr_ff;
   logic [ID_BITS-1:0]    rsp_addr_in;

   logic advance;
   logic step_fire;
   logic req_fire;

   // Result register frees up when empty or when its transfer completes this cycle.
   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire  = req_chan.valid && req_chan.ready;

   ors_step #(
      .ID_BITS (ID_BITS)
   ) u_step (
      .item     (in_item_ff),
      .ctl_q    (ctl_ff),
      .rom_q    (rom_ff),
      .ctl_d    (ctl_in),
      .rom_d    (rom_in),
      .result   (rsp_item_in),
      .dev_addr (rsp_addr_in)
   );

   // Input register: load on every request transfer, drain when the step fires.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.command        <= req_chan.command;
         in_item_ff.fam_byte       <= req_chan.fam_byte;
         in_item_ff.presence       <= req_chan.presence;
         in_item_ff.search_opcode  <= req_chan.search_opcode;
         in_item_ff.id_bit         <= req_chan.id_bit;
         in_item_ff.complement_bit <= req_chan.complement_bit;
      end
   end

   // Search state advances only when a step fires, so a stall leaves it untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.last_disc   <= '0;
         ctl_ff.last_dev    <= 1'b0;
         ctl_ff.fam_disc    <= '0;
         ctl_ff.bit_pos     <= ors_pkg::POS_W'(1);
         ctl_ff.zero_mark   <= '0;
         ctl_ff.pass_active <= 1'b0;
         rom_ff             <= '0;
      end else if (step_fire) begin
         ctl_ff <= ctl_in;
         rom_ff <= rom_in;
      end
   end

   // Result register: refill when free, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_item_ff <= rsp_item_in;
         rsp_addr_ff <= rsp_addr_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_item_ff.status;
   assign rsp_chan.write_bit          = rsp_item_ff.write_bit;
   assign rsp_chan.send_byte          = rsp_item_ff.send_byte;
   assign rsp_chan.device_address     = rsp_addr_ff;
   assign rsp_chan.last_device        = rsp_item_ff.last_device;
   assign rsp_chan.family_discrepancy = rsp_item_ff.family_discrepancy;

   // Bit position stays within the ROM code between steps.
   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.bit_pos >= ors_pkg::POS_W'(1) && ctl_ff.bit_pos <= ors_pkg::POS_W'(ID_BITS))
      else $error("bit position out of range");

   // A found device never carries a zero family byte.
   a_found_family: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status == ors_pkg::ST_FOUND |-> rsp_addr_ff[7:0] != 8'd0)
      else $error("found device with zero family byte");

   // Any ending with no device clears the search summary reported alongside it.
   a_none_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status == ors_pkg::ST_NONE ||
                       rsp_item_ff.status == ors_pkg::ST_WRITE_NONE)
      |-> !rsp_item_ff.last_device && rsp_item_ff.family_discrepancy == '0)
      else $error("search state not cleared on none");

   // A rejected bit pair leaves the search state as it was.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      step_fire && rsp_item_in.status == ors_pkg::ST_REJECT |=> $stable(ctl_ff) && $stable(rom_ff))
      else $error("rejected bit pair changed search state");
endmodule
